>>> rtl/core/qmt_pkg.sv
// Shared types and constants for the quaternion matrix transform block.
// No dependencies.
package qmt_pkg;

    localparam int ELEM_W = 32;
    localparam int NUM_TERMS = 9;

    typedef enum logic [1:0] {
        REQ_COL   = 2'd0,
        REQ_ROT   = 2'd1,
        REQ_TRANS = 2'd2,
        REQ_XFORM = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_RPROD,
        ST_RDIV,
        ST_RSTORE,
        ST_RWRITE,
        ST_XFORM,
        ST_XOUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_TERM,
        MUL_X
    } mul_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic       cap;
        logic       load_col;
        logic       load_trans;
        logic [1:0] col;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic [1:0] idx_a;
        logic [1:0] idx_b;
        logic [3:0] mat_idx;
        logic       norm_acc;
        logic       div_init;
        logic       div_step;
        logic       term_store;
        logic [3:0] term_idx;
        logic       rot_write;
        logic       x_acc;
        logic       x_first;
        logic       x_last;
        logic [1:0] x_row;
        logic       out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
    } sts_t;

    // term order: xx yy zz xy xz yz wx wy wz (x=0 y=1 z=2 w=3)
    function automatic logic [3:0] term_ops(input logic [3:0] t);
        logic [3:0] r;
        case (t)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd1, 2'd1};
            4'd2:    r = {2'd2, 2'd2};
            4'd3:    r = {2'd0, 2'd1};
            4'd4:    r = {2'd0, 2'd2};
            4'd5:    r = {2'd1, 2'd2};
            4'd6:    r = {2'd3, 2'd0};
            4'd7:    r = {2'd3, 2'd1};
            4'd8:    r = {2'd3, 2'd2};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/quaternion_matrix_transform.sv
// Top level of the quaternion matrix transform block: sequencer plus datapath.
// Depends on qmt_pkg, qmt_ctrl, qmt_dp.
//
//  channel  dir  tdata                        tuser
//  s_axis   in   elem_a..elem_d (128 bits)    req_type, column_index
//  m_axis   out  out_a..out_d   (128 bits)    -
//
// Load column and load translation: written on acceptance, ready again next cycle.
// Transform: products through the single shared 32x32 multiplier, a drain step,
// then the output register is loaded (held back while that register is not taken).
// Rotation: norm accumulation, then per term a product, a restoring divide and a
// store, over nine terms, then the matrix write.
// Reset: matrix returns to identity at once, no clearing pass.
// A full output register stalls only the next transform at its last step.
module quaternion_matrix_transform import qmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // elem_a, elem_b, elem_c, elem_d
    input  logic [3:0]   s_axis_tuser,   // req_type[1:0], column_index[3:2]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // out_a, out_b, out_c, out_d
);

    cmd_t cmd;
    sts_t sts;

    qmt_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_kind  (s_axis_tuser[1:0]),
        .req_col   (s_axis_tuser[3:2]),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    qmt_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_a      (s_axis_tdata[31:0]),
        .in_b      (s_axis_tdata[63:32]),
        .in_c      (s_axis_tdata[95:64]),
        .in_d      (s_axis_tdata[127:96]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> rtl/core/qmt_ctrl.sv
// Sequencer for the quaternion matrix transform block.
// Depends on qmt_pkg.
module qmt_ctrl import qmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_kind,
    input  logic [1:0] req_col,
    output logic       req_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] term_reg, term_next;
    logic       acc;
    logic [4:0] k;

    assign req_ready = (state_reg == ST_IDLE);
    assign acc = req_valid && req_ready;
    assign k = cnt_reg - 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next  = '0;
                term_next = '0;
                if (acc && req_kind == REQ_ROT)
                    state_next = ST_NORM;
                else if (acc && req_kind == REQ_XFORM)
                    state_next = ST_XFORM;
            end
            ST_NORM:
            begin
                if (cnt_reg == 5'd4)
                begin
                    state_next = ST_RPROD;
                    cnt_next   = '0;
                end
            end
            ST_RPROD:
            begin
                state_next = ST_RDIV;
                cnt_next   = '0;
            end
            ST_RDIV:
            begin
                if (cnt_reg == 5'(FRAC_BITS))
                    state_next = ST_RSTORE;
            end
            ST_RSTORE:
            begin
                cnt_next  = '0;
                term_next = term_reg + 4'd1;
                if (term_reg == 4'(NUM_TERMS - 1))
                    state_next = ST_RWRITE;
                else
                    state_next = ST_RPROD;
            end
            ST_RWRITE:
                state_next = ST_IDLE;
            ST_XFORM:
            begin
                if (cnt_reg == 5'd16)
                    state_next = ST_XOUT;
            end
            ST_XOUT:
            begin
                if (!sts.out_full)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MUL_SQ;
        cmd.col = req_col;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.cap        = acc;
                cmd.load_col   = acc && req_kind == REQ_COL;
                cmd.load_trans = acc && req_kind == REQ_TRANS;
            end
            ST_NORM:
            begin
                cmd.mul_en   = (cnt_reg < 5'd4);
                cmd.idx_a    = cnt_reg[1:0];
                cmd.idx_b    = cnt_reg[1:0];
                cmd.norm_acc = (cnt_reg != 5'd0);
            end
            ST_RPROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TERM;
                {cmd.idx_a, cmd.idx_b} = term_ops(term_reg);
            end
            ST_RDIV:
            begin
                cmd.div_init = (cnt_reg == 5'd0);
                cmd.div_step = (cnt_reg != 5'd0);
            end
            ST_RSTORE:
            begin
                cmd.term_store = 1'b1;
                cmd.term_idx   = term_reg;
            end
            ST_RWRITE:
                cmd.rot_write = 1'b1;
            ST_XFORM:
            begin
                // entry col*4+row with row = cnt[3:2], col = cnt[1:0]
                cmd.mul_en  = (cnt_reg < 5'd16);
                cmd.mul_sel = MUL_X;
                cmd.mat_idx = {cnt_reg[1:0], cnt_reg[3:2]};
                cmd.idx_b   = cnt_reg[1:0];
                cmd.x_acc   = (cnt_reg != 5'd0);
                cmd.x_first = (k[1:0] == 2'd0);
                cmd.x_last  = (k[1:0] == 2'd3);
                cmd.x_row   = k[3:2];
            end
            ST_XOUT:
                cmd.out_load = !sts.out_full;
            default:
                cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/qmt_dp.sv
// Datapath: matrix registers, shared multiplier, norm, divider, accumulator, output.
// Depends on qmt_pkg.
module qmt_dp import qmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [ELEM_W-1:0] in_a,
    input  logic signed [ELEM_W-1:0] in_b,
    input  logic signed [ELEM_W-1:0] in_c,
    input  logic signed [ELEM_W-1:0] in_d,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [4*ELEM_W-1:0]      out_data
);

    localparam int TW = FRAC_BITS + 2;
    localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    logic signed [ELEM_W-1:0] mat_reg [16];
    logic signed [ELEM_W-1:0] e_reg [4];
    logic signed [ELEM_W-1:0] in_e [4];
    logic signed [63:0]       prod_reg;
    logic [64:0]              nacc_reg;
    logic [63:0]              rem_reg;
    logic [FRAC_BITS:0]       quo_reg;
    logic                     neg_reg;
    logic                     fixed_reg;
    logic signed [TW-1:0]     term_reg [NUM_TERMS];
    logic signed [65:0]       acc_reg;
    logic signed [ELEM_W-1:0] res_reg [4];
    logic                     out_valid_reg;
    logic [4*ELEM_W-1:0]      out_data_reg;

    logic signed [ELEM_W-1:0] mul_a, mul_b;
    logic [63:0]              n64, mag, dividend;
    logic [64:0]              rem_s;
    logic                     take;
    logic signed [65:0]       sum_w, shifted;
    logic signed [ELEM_W-1:0] sat_v;
    logic signed [ELEM_W-1:0] t [NUM_TERMS];

    assign in_e[0] = in_a;
    assign in_e[1] = in_b;
    assign in_e[2] = in_c;
    assign in_e[3] = in_d;

    always_comb
    begin
        mul_a = e_reg[cmd.idx_a];
        mul_b = e_reg[cmd.idx_b];
        case (cmd.mul_sel)
            MUL_SQ, MUL_TERM: mul_a = e_reg[cmd.idx_a];
            MUL_X:            mul_a = mat_reg[cmd.mat_idx];
            default:          mul_a = e_reg[cmd.idx_a];
        endcase
    end

    // norm saturates at 2^64-1
    assign n64 = nacc_reg[64] ? {64{1'b1}} : nacc_reg[63:0];
    assign mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign dividend = {mag[62:0], 1'b0};
    assign rem_s = {rem_reg, 1'b0};
    assign take = (rem_s >= {1'b0, n64});

    assign sum_w = (cmd.x_first ? 66'sd0 : acc_reg) + 66'(prod_reg);
    assign shifted = sum_w >>> FRAC_BITS;
    assign sat_v = (shifted > SAT_HI) ? ELEM_W'(SAT_HI) :
                   (shifted < SAT_LO) ? ELEM_W'(SAT_LO) : shifted[ELEM_W-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
            t[i] = ELEM_W'(term_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? ONE : '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_col)
            begin
                for (int i = 0; i < 4; i++)
                    mat_reg[{cmd.col, 2'(i)}] <= in_e[i];
            end
            if (cmd.load_trans)
            begin
                for (int i = 0; i < 16; i++)
                    mat_reg[i] <= (i % 5 == 0) ? ONE : '0;
                mat_reg[12] <= in_a;
                mat_reg[13] <= in_b;
                mat_reg[14] <= in_c;
            end
            if (cmd.rot_write)
            begin
                // terms: 0 xx 1 yy 2 zz 3 xy 4 xz 5 yz 6 wx 7 wy 8 wz
                mat_reg[0]  <= ONE - (t[1] + t[2]);
                mat_reg[1]  <= t[3] + t[8];
                mat_reg[2]  <= t[4] - t[7];
                mat_reg[3]  <= '0;
                mat_reg[4]  <= t[3] - t[8];
                mat_reg[5]  <= ONE - (t[0] + t[2]);
                mat_reg[6]  <= t[5] + t[6];
                mat_reg[7]  <= '0;
                mat_reg[8]  <= t[4] + t[7];
                mat_reg[9]  <= t[5] - t[6];
                mat_reg[10] <= ONE - (t[0] + t[1]);
                mat_reg[11] <= '0;
                mat_reg[12] <= '0;
                mat_reg[13] <= '0;
                mat_reg[14] <= '0;
                mat_reg[15] <= ONE;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            for (int i = 0; i < 4; i++)
                e_reg[i] <= in_e[i];
            nacc_reg <= '0;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.norm_acc)
            nacc_reg <= nacc_reg + {1'b0, prod_reg};
        if (cmd.div_init)
        begin
            neg_reg <= prod_reg[63];
            rem_reg <= dividend;
            if (n64 == '0)
            begin
                quo_reg   <= '0;
                fixed_reg <= 1'b1;
            end
            else if (dividend >= n64)
            begin
                quo_reg   <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                fixed_reg <= 1'b1;
            end
            else
            begin
                quo_reg   <= '0;
                fixed_reg <= 1'b0;
            end
        end
        if (cmd.div_step && !fixed_reg)
        begin
            rem_reg <= take ? 64'(rem_s - {1'b0, n64}) : rem_s[63:0];
            quo_reg <= {quo_reg[FRAC_BITS-1:0], take};
        end
        if (cmd.term_store)
            term_reg[cmd.term_idx] <= neg_reg ? -$signed({1'b0, quo_reg})
                                              : $signed({1'b0, quo_reg});
        if (cmd.x_acc)
        begin
            acc_reg <= sum_w;
            if (cmd.x_last)
                res_reg[cmd.x_row] <= sat_v;
        end
        if (cmd.out_load)
            out_data_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    end

    assign sts.out_full = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

>>> rtl/core/qmt_checker.sv
// Port-level checks for quaternion_matrix_transform, bound to the top level.
// Depends on qmt_pkg.
module qmt_checker import qmt_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [3:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_col_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser[1:0] == REQ_COL || s_axis_tuser[1:0] == REQ_TRANS)
        |=> s_axis_tready)
        else $error("load request did not finish in one cycle");

    a_xform_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser[1:0] == REQ_XFORM |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("transform request not held busy");

    a_rot_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser[1:0] == REQ_ROT |=> !$rose(m_axis_tvalid) && !s_axis_tready)
        else $error("rotation load produced a result or ended early");

endmodule

bind quaternion_matrix_transform qmt_checker u_qmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/quaternion_matrix_transform_tb.sv
`timescale 1ns / 1ps
// Testbench for quaternion_matrix_transform: directed table, then random requests.
// Uses qmt_pkg; every transform result is checked against the matrix predictor below or a typed row's value.
module quaternion_matrix_transform_tb;
    import qmt_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    typedef struct {
        req_t         req;
        logic [1:0]   col;
        logic [127:0] data;
        bit           typed;
        logic [127:0] want;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    // predictor state: column-major, entry col*4+row
    logic signed [31:0] model_mat [16];
    logic [127:0]       pending_vecs [$];
    stim_row_t          table_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_arm = 1'b0;
    int hold_left = 0;
    int err_count = 0;
    int n_xform = 0, n_rot = 0, n_load = 0, n_seen = 0;

    quaternion_matrix_transform #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [127:0] pack4(input logic [31:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    function automatic void load_identity();
        for (int i = 0; i < 16; i++)
            model_mat[i] = (i % 5 == 0) ? ONE : '0;
    endfunction

    // 2*p*q/n, truncated toward zero, via the same restoring divide
    function automatic longint unsigned_div_term(input longint p, q,
                                                 input logic [63:0] n);
        logic signed [63:0] prod;
        logic [63:0] mag, dividend, quo, rem;
        logic top;
        bit neg;
        prod = p * q;
        neg = prod < 0;
        mag = neg ? -prod : prod;
        dividend = mag << 1;
        quo = '0;
        if (n == 0)
            return 0;
        if (dividend >= n)
            quo = 64'd1 << FRAC_BITS;
        else
        begin
            rem = dividend;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                top = rem[63];
                rem = rem << 1;
                quo = quo << 1;
                if (top || rem >= n)
                begin
                    rem = rem - n;
                    quo[0] = 1'b1;
                end
            end
        end
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic void build_rotation(input logic [127:0] d);
        longint e [4];
        logic [64:0] norm;
        logic [63:0] n;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
        one = ONE;
        norm = '0;
        for (int i = 0; i < 4; i++)
        begin
            e[i] = longint'($signed(d[32*i +: 32]));
            norm = norm + 65'(64'(e[i] * e[i]));
        end
        n = norm[64] ? '1 : norm[63:0];  // only all-minimum inputs overflow
        xx = unsigned_div_term(e[0], e[0], n);
        yy = unsigned_div_term(e[1], e[1], n);
        zz = unsigned_div_term(e[2], e[2], n);
        xy = unsigned_div_term(e[0], e[1], n);
        xz = unsigned_div_term(e[0], e[2], n);
        yz = unsigned_div_term(e[1], e[2], n);
        wx = unsigned_div_term(e[3], e[0], n);
        wy = unsigned_div_term(e[3], e[1], n);
        wz = unsigned_div_term(e[3], e[2], n);
        model_mat[0]  = 32'(one - (yy + zz));
        model_mat[1]  = 32'(xy + wz);
        model_mat[2]  = 32'(xz - wy);
        model_mat[3]  = '0;
        model_mat[4]  = 32'(xy - wz);
        model_mat[5]  = 32'(one - (xx + zz));
        model_mat[6]  = 32'(yz + wx);
        model_mat[7]  = '0;
        model_mat[8]  = 32'(xz + wy);
        model_mat[9]  = 32'(yz - wx);
        model_mat[10] = 32'(one - (xx + yy));
        model_mat[11] = '0;
        model_mat[12] = '0;
        model_mat[13] = '0;
        model_mat[14] = '0;
        model_mat[15] = ONE;
    endfunction

    // exact sum of four products, floor shift, saturate to 32 bits
    function automatic logic [127:0] transform_vec(input logic [127:0] d);
        logic signed [67:0] acc, m, x, sh;
        logic [127:0] res;
        for (int r = 0; r < 4; r++)
        begin
            acc = '0;
            for (int c = 0; c < 4; c++)
            begin
                m = model_mat[c*4 + r];
                x = $signed(d[32*c +: 32]);
                acc = acc + m * x;
            end
            sh = acc >>> FRAC_BITS;
            if (sh > $signed(68'(SMAX)))
                res[32*r +: 32] = SMAX;
            else if (sh < -68'sd2147483648)
                res[32*r +: 32] = SMIN;
            else
                res[32*r +: 32] = sh[31:0];
        end
        return res;
    endfunction

    // advance the predictor by one accepted request
    function automatic void apply_request(input req_t req, input logic [1:0] col,
                                          input logic [127:0] d, input bit typed,
                                          input logic [127:0] want);
        case (req)
            REQ_COL:
            begin
                for (int i = 0; i < 4; i++)
                    model_mat[col*4 + i] = d[32*i +: 32];
                n_load++;
            end
            REQ_ROT:
            begin
                build_rotation(d);
                n_rot++;
            end
            REQ_TRANS:
            begin
                load_identity();
                for (int i = 0; i < 3; i++)
                    model_mat[12 + i] = d[32*i +: 32];
                n_load++;
            end
            default:
            begin
                pending_vecs.push_back(typed ? want : transform_vec(d));
                n_xform++;
            end
        endcase
    endfunction

    task automatic send_request(input req_t req, input logic [1:0] col,
                                input logic [127:0] d, input bit typed = 1'b0,
                                input logic [127:0] want = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {col, req};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(req, col, d, typed, want);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(9))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            3, 4, 5: return $urandom;
            default: return 32'($signed($urandom_range(8 * ONE)) - $signed(4 * ONE));
        endcase
    endfunction

    function automatic logic [127:0] rand_quat();
        logic [127:0] q;
        case ($urandom_range(7))
            0:       q = '0;
            1:       q = pack4($urandom, $urandom, $urandom, $urandom);
            2:       q = pack4(SMIN, SMIN, SMIN, SMIN);
            default:
                for (int i = 0; i < 4; i++)
                    q[32*i +: 32] = 32'($signed($urandom_range(2 * ONE)) - $signed(ONE));
        endcase
        return q;
    endfunction

    task automatic random_requests(input int count);
        int pick;
        logic [127:0] d;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            d = pack4(rand_elem(), rand_elem(), rand_elem(), rand_elem());
            if (pick < 3)
                send_request(REQ_ROT, 2'($urandom), rand_quat());
            else if (pick < 15)
                send_request(REQ_COL, 2'($urandom), d);
            else if (pick < 20)
                send_request(REQ_TRANS, 2'($urandom), d);
            else
                send_request(REQ_XFORM, 2'($urandom), d);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_vecs.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_arm && hold_left == 0)
        begin
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        logic [127:0] want;
        string names [4];
        names = '{"out_a", "out_b", "out_c", "out_d"};
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_seen++;
            if (pending_vecs.size() == 0)
            begin
                $error("result with no transform request outstanding: %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = pending_vecs.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32])
                    begin
                        $error("%s expected %h got %h", names[i], want[32*i +: 32],
                               m_axis_tdata[32*i +: 32]);
                        err_count++;
                    end
            end
        end
    end

    function automatic void add_row(input req_t req, input logic [1:0] col,
                                    input logic [127:0] d, input bit typed = 1'b0,
                                    input logic [127:0] want = '0);
        stim_row_t row;
        row.req = req;
        row.col = col;
        row.data = d;
        row.typed = typed;
        row.want = want;
        table_rows.push_back(row);
    endfunction

    initial
    begin
        load_identity();
        // identity after reset passes the vector straight through
        add_row(REQ_XFORM, 2'd0, pack4(SMAX, SMIN, 0, '1), 1'b1, pack4(SMAX, SMIN, 0, '1));
        add_row(REQ_XFORM, 2'd2, pack4(ONE, -ONE, 5, 32'hAAAA_5555), 1'b1,
                pack4(ONE, -ONE, 5, 32'hAAAA_5555));
        // translation: unit w picks out column three
        add_row(REQ_TRANS, 2'd1, pack4(ONE, -2 * ONE, SMAX, SMIN));
        add_row(REQ_XFORM, 2'd0, pack4(0, 0, 0, ONE), 1'b1, pack4(ONE, -2 * ONE, SMAX, ONE));
        // extreme columns, saturation both ways
        add_row(REQ_COL, 2'd0, pack4(SMAX, SMAX, SMAX, SMAX));
        add_row(REQ_COL, 2'd1, pack4(SMIN, SMIN, SMIN, SMIN));
        add_row(REQ_COL, 2'd2, pack4(ONE, '1, SMAX, 0));
        add_row(REQ_COL, 2'd3, pack4(0, SMIN, 1, '1));
        add_row(REQ_XFORM, 2'd1, pack4(SMAX, SMAX, SMAX, SMAX));
        add_row(REQ_XFORM, 2'd3, pack4(SMIN, SMIN, SMIN, SMIN));
        add_row(REQ_XFORM, 2'd0, pack4(SMAX, SMIN, SMAX, SMIN));
        // zero-norm quaternion yields identity
        add_row(REQ_ROT, 2'd2, '0);
        add_row(REQ_XFORM, 2'd0, pack4(5, -7, SMAX, SMIN), 1'b1, pack4(5, -7, SMAX, SMIN));
        // norm overflow: all components at minimum
        add_row(REQ_ROT, 2'd0, pack4(SMIN, SMIN, SMIN, SMIN));
        add_row(REQ_XFORM, 2'd0, pack4(ONE, 2 * ONE, 3 * ONE, ONE));
        add_row(REQ_ROT, 2'd0, pack4(0, 0, 0, ONE));
        add_row(REQ_XFORM, 2'd0, pack4(ONE, 2 * ONE, 3 * ONE, ONE));
        add_row(REQ_ROT, 2'd0, pack4(ONE, 0, 0, 0));
        add_row(REQ_XFORM, 2'd0, pack4(ONE, 2 * ONE, 3 * ONE, ONE));
        add_row(REQ_ROT, 2'd3, pack4(ONE, ONE, ONE, ONE));
        add_row(REQ_XFORM, 2'd0, pack4(ONE, 2 * ONE, 3 * ONE, ONE));
        add_row(REQ_ROT, 2'd1, pack4(SMAX, SMIN, 32'h1234_5678, '1));
        add_row(REQ_XFORM, 2'd0, pack4(SMAX, SMAX, SMIN, ONE));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_request(table_rows[i].req, table_rows[i].col, table_rows[i].data,
                         table_rows[i].typed, table_rows[i].want);
        drain_results();

        // no idling on either side
        send_idle_pct = 0;  recv_stall_pct = 0;
        random_requests(500);
        drain_results();

        send_idle_pct = 47; recv_stall_pct = 0;
        random_requests(450);

        send_idle_pct = 0;  recv_stall_pct = 47;
        random_requests(450);

        // long receiver hold-off while requests keep coming
        hold_arm <= 1'b1;
        send_idle_pct = 0;
        for (int k = 0; k < 40; k++)
        begin
            send_request(REQ_XFORM, 2'd0, pack4(rand_elem(), rand_elem(),
                         rand_elem(), rand_elem()));
            if (k == 0)
                hold_arm <= 1'b0;
        end
        drain_results();

        send_idle_pct = 7;  recv_stall_pct = 7;
        random_requests(480);
        drain_results();

        $display("covered %0d transforms, %0d rotations, %0d column/translation loads",
                 n_xform, n_rot, n_load);
        $display("results checked: %0d, mismatches: %0d", n_seen, err_count);
        repeat (200) @(posedge clk);
        if (err_count == 0 && pending_vecs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
